// ===== rtl/core/pcm_pkg.sv =====
// Shared constants, state machine type and the control structs for the partition counter.
// Used by pcm_table and by the top level partition_count_mod; depends on nothing else.
package pcm_pkg;

   localparam int MAX_N  = 1024;
   localparam int IDX_W  = $clog2(MAX_N);
   localparam int TGT_W  = 10;
   localparam int RES_W  = 20;
   localparam int MOD_W  = 21;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [MOD_W-1:0] MOD_MIN   = 21'd2;
   localparam logic [MOD_W-1:0] MOD_MAX   = 21'd1048576;
   localparam logic [MOD_W-1:0] MOD_RESET = 21'd1000000;

   localparam logic CSR_IDX_MODULUS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             clr_we;
      logic [IDX_W-1:0] clr_addr;
      logic             clr_one;
      logic             rd_en;
      logic [IDX_W-1:0] addr_j;
      logic [IDX_W-1:0] addr_i;
   } tbl_cmd_type;

   typedef struct packed {
      logic             wr_valid;
      logic [RES_W-1:0] wr_data;
   } tbl_stat_type;

endpackage

// ===== rtl/core/pcm_table.sv =====
// Scratch table of partial counts with a two-stage read, add and write-back pipeline.
// Depends on pcm_pkg for widths and the command and status structs.
module pcm_table
   import pcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tbl_cmd_type        cmd,
   input  logic [MOD_W-1:0]   modulus,
   output tbl_stat_type       stat
);

   logic [RES_W-1:0] mem [MAX_N];

   logic [RES_W-1:0] rd_j_ff;
   logic [RES_W-1:0] rd_i_ff;
   logic             upd_ff;
   logic             upd_in;
   logic [IDX_W-1:0] wr_addr_ff;
   logic             hit_j_ff;
   logic             hit_j_in;
   logic             hit_i_ff;
   logic             hit_i_in;
   logic [RES_W-1:0] fwd_data_ff;

   logic [RES_W-1:0] op_j;
   logic [RES_W-1:0] op_i;
   logic [MOD_W-1:0] sum;
   logic [MOD_W-1:0] red;
   logic [RES_W-1:0] wr_data;
   logic             we;
   logic [IDX_W-1:0] we_addr;
   logic [RES_W-1:0] we_data;

   // An operand read in the same cycle as the write to its entry takes the written value.
   assign op_j    = hit_j_ff ? fwd_data_ff : rd_j_ff;
   assign op_i    = hit_i_ff ? fwd_data_ff : rd_i_ff;
   assign sum     = {1'b0, op_j} + {1'b0, op_i};
   assign red     = (sum >= modulus) ? (sum - modulus) : sum;
   assign wr_data = red[RES_W-1:0];

   assign upd_in   = cmd.rd_en;
   assign hit_j_in = upd_ff && (wr_addr_ff == cmd.addr_j);
   assign hit_i_in = upd_ff && (wr_addr_ff == cmd.addr_i);

   assign we      = cmd.clr_we || upd_ff;
   assign we_addr = cmd.clr_we ? cmd.clr_addr : wr_addr_ff;
   assign we_data = cmd.clr_we ? {{(RES_W-1){1'b0}}, cmd.clr_one} : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[we_addr] <= we_data;
      end
      if (cmd.rd_en) begin
         rd_j_ff <= mem[cmd.addr_j];
         rd_i_ff <= mem[cmd.addr_i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff <= 1'b0;
      end else begin
         upd_ff <= upd_in;
      end
      wr_addr_ff  <= cmd.addr_j;
      hit_j_ff    <= hit_j_in;
      hit_i_ff    <= hit_i_in;
      fwd_data_ff <= wr_data;
   end

   assign stat.wr_valid = upd_ff;
   assign stat.wr_data  = wr_data;

endmodule

// ===== rtl/core/partition_count_mod.sv =====
// Partition count p(n) modulo a programmable modulus, with a scratch table in memory.
// An item with target n clears n+1 table entries, makes n(n+1)/2 table updates at one per cycle
// and then passes a drain state before rsp_valid rises in the done state.
// busy stays high through the result cycle, so a new item is accepted only after the result;
// n = 0 skips the update and drain states. No output stall.
// Reset clears the control state and sets the modulus to 1000000. Uses pcm_pkg, pcm_table.
module partition_count_mod
   import pcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [TGT_W-1:0]  req_target_count,
   output logic              rsp_valid,
   output logic [RES_W-1:0]  rsp_count_residue,
   output logic              rsp_divisible,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] n_ff;
   logic [IDX_W-1:0] n_in;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] j_in;
   logic [IDX_W-1:0] k_ff;
   logic [IDX_W-1:0] k_in;
   logic [RES_W-1:0] result_ff;
   logic [RES_W-1:0] result_in;
   logic [MOD_W-1:0] modulus_ff;
   logic [MOD_W-1:0] eff_mod;
   logic             csr_write;
   tbl_cmd_type      cmd;
   tbl_stat_type     stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_MODULUS) ?
                      {{(CSR_DW-MOD_W){1'b0}}, modulus_ff} : '0;

   assign eff_mod = (modulus_ff < MOD_MIN) ? MOD_MIN :
                    (modulus_ff > MOD_MAX) ? MOD_MAX : modulus_ff;

   pcm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .modulus (eff_mod),
      .stat    (stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (j_ff == n_ff) begin
               state_in = (n_ff == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if ((j_ff == n_ff) && (k_ff == n_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      n_in      = n_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      result_in = stat.wr_valid ? stat.wr_data : result_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (int'(req_target_count) >= MAX_N) begin
                  n_in = IDX_W'(MAX_N - 1);
               end else begin
                  n_in = IDX_W'(req_target_count);
               end
               j_in = '0;
            end
         end
         ST_CLEAR: begin
            cmd.clr_we   = 1'b1;
            cmd.clr_addr = j_ff;
            cmd.clr_one  = (j_ff == '0);
            if (j_ff == n_ff) begin
               j_in      = IDX_W'(1);
               k_in      = IDX_W'(1);
               result_in = RES_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_RUN: begin
            cmd.rd_en  = 1'b1;
            cmd.addr_j = j_ff;
            cmd.addr_i = j_ff - k_ff;
            if (j_ff == n_ff) begin
               if (k_ff != n_ff) begin
                  k_in = k_ff + IDX_W'(1);
                  j_in = k_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_count_residue = result_ff;
   assign rsp_divisible     = (result_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= MOD_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write && (paddr[2] == CSR_IDX_MODULUS)) begin
            modulus_ff <= pwdata[MOD_W-1:0];
         end
      end
      n_ff      <= n_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      result_ff <= result_in;
   end

`ifndef NO_ASSERTIONS
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not raise busy");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !stat.wr_valid)
      else $error("table write-back while idle");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_DRAIN || $past(state_ff) == ST_CLEAR))
      else $error("result without finished table pass");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for partition_count_mod: drives target counts and modulus writes,
// predicts p(n) mod m in a scratch table of its own and checks every result in order.
// Depends on pcm_pkg and the partition_count_mod RTL only.
module testbench;
   import pcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_AW-1:0] MODULUS_ADDR = CSR_AW'(4 * int'(CSR_IDX_MODULUS));

   typedef enum logic {
      JOB_COUNT,
      JOB_SET_MODULUS
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  value;
   } job_type;

   typedef struct packed {
      logic [RES_W-1:0] residue;
      logic             divisible;
   } partition_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [TGT_W-1:0]  req_target_count = '0;
   logic              rsp_valid;
   logic [RES_W-1:0]  rsp_count_residue;
   logic              rsp_divisible;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   job_type              job_queue[$];
   partition_result_type expected_residues[$];
   logic [MOD_W-1:0]     modulus_setting = MOD_RESET;
   int                   outstanding = 0;
   int                   counts_loaded = 0;
   int                   failures = 0;
   int                   quiet_cycles = 0;

   partition_count_mod u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_target_count  (req_target_count),
      .rsp_valid         (rsp_valid),
      .rsp_count_residue (rsp_count_residue),
      .rsp_divisible     (rsp_divisible),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   function automatic partition_result_type partition_residue(input int unsigned n,
                                                              input logic [MOD_W-1:0] setting);
      int unsigned ways [MAX_N];
      int unsigned m;
      int unsigned s;
      int unsigned final_count;
      partition_result_type r;
      m = setting;
      if (m < MOD_MIN) begin
         m = MOD_MIN;
      end
      if (m > MOD_MAX) begin
         m = MOD_MAX;
      end
      foreach (ways[i]) begin
         ways[i] = 0;
      end
      ways[0] = 1;
      for (int k = 1; k <= int'(n); k++) begin
         for (int j = k; j <= int'(n); j++) begin
            s = ways[j] + ways[j - k];
            if (s >= m) begin
               s = s - m;
            end
            ways[j] = s;
         end
      end
      final_count = ways[n] % m;
      r.residue = RES_W'(final_count);
      r.divisible = (final_count == 0);
      return r;
   endfunction

   function automatic logic pause_now();
      if (counts_loaded >= 45 && counts_loaded < 75) begin
         return 1'b0;
      end
      return $urandom_range(99) < 29;
   endfunction

   task automatic add_count(input int unsigned n);
      job_queue.push_back('{kind: JOB_COUNT, value: 32'(n)});
   endtask

   task automatic add_modulus(input logic [31:0] v);
      job_queue.push_back('{kind: JOB_SET_MODULUS, value: v});
   endtask

   // Driver: one job at a time; a modulus write waits until every result is back.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_target_count <= '0;
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         paddr <= '0;
         pwdata <= '0;
      end else if (psel && !penable) begin
         penable <= 1'b1;
      end else if (psel && penable) begin
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
      end else if (start && !busy) begin
         if (job_queue.size() > 0 && job_queue[0].kind == JOB_COUNT && !pause_now()) begin
            req_target_count <= TGT_W'(job_queue[0].value);
            void'(job_queue.pop_front());
            counts_loaded <= counts_loaded + 1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && job_queue.size() > 0) begin
         if (job_queue[0].kind == JOB_SET_MODULUS) begin
            if (outstanding == 0 && !busy) begin
               psel <= 1'b1;
               pwrite <= 1'b1;
               paddr <= MODULUS_ADDR;
               pwdata <= job_queue[0].value;
               void'(job_queue.pop_front());
            end
         end else if (!pause_now()) begin
            start <= 1'b1;
            req_target_count <= TGT_W'(job_queue[0].value);
            void'(job_queue.pop_front());
            counts_loaded <= counts_loaded + 1;
         end
      end
   end

   // Monitor: owns the predicted modulus and the queue of expected results.
   always @(posedge clock) begin
      partition_result_type want;
      if (reset) begin
         modulus_setting <= MOD_RESET;
         expected_residues.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_residues.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual residue %0d divisible %0b",
                        $time, rsp_count_residue, rsp_divisible);
               failures++;
            end else begin
               want = expected_residues.pop_front();
               if (rsp_count_residue !== want.residue) begin
                  $display("%0t: count_residue mismatch: expected %0d, actual %0d",
                           $time, want.residue, rsp_count_residue);
                  failures++;
               end
               if (rsp_divisible !== want.divisible) begin
                  $display("%0t: divisible mismatch: expected %0b, actual %0b",
                           $time, want.divisible, rsp_divisible);
                  failures++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == MODULUS_ADDR) begin
            modulus_setting <= pwdata[MOD_W-1:0];
         end
         if (start && !busy) begin
            expected_residues.push_back(partition_residue(req_target_count, modulus_setting));
         end
         outstanding <= expected_residues.size();
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int unsigned pick;
      foreach (job_queue[i]) begin
      end
      add_count(0);
      add_count(1);
      add_count(2);
      add_count(5);
      add_count(30);
      add_count(60);
      add_modulus(32'd0);
      add_count(0);
      add_count(2);
      add_count(3);
      add_count(7);
      add_modulus(32'd1);
      add_count(1);
      add_count(8);
      add_modulus(32'd3);
      add_count(3);
      add_count(6);
      add_modulus(32'hFFFF_FFFF);
      add_count(1023);
      add_count(0);
      add_modulus(32'd1048577);
      add_count(40);
      add_modulus(32'd1048575);
      add_count(100);
      add_modulus(32'd5);
      add_count(4);
      add_count(9);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase % 3)
            0: add_modulus($urandom_range(40, 2));
            1: add_modulus($urandom());
            default: add_modulus($urandom_range(1048576, 900000));
         endcase
         for (int i = 0; i < 20; i++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
               add_count($urandom_range(48, 0));
            end else if (pick < 95) begin
               add_count($urandom_range(160, 49));
            end else begin
               add_count($urandom_range(300, 161));
            end
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Sampled away from the rising edge so that the driver and monitor updates have settled.
      do begin
         @(negedge clock);
      end while (job_queue.size() != 0 || start || psel || outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
